// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the console writer modules.
// Both are clocked on clock and held off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge.
`define TCW_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define TCW_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tcw_pkg.sv -----
package tcw_pkg;

   // Grid geometry
   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STOP = 8;

   // Field and state widths
   localparam int COL_W    = $clog2(COLUMNS + 1);
   localparam int END_W    = COL_W + 1;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int POS_W    = 11;
   localparam int LEN_W    = 7;
   localparam int GLYPH_W  = 8;
   localparam int ATTR_W   = 8;
   localparam int VALUE_W  = 32;
   localparam int NIBBLES  = VALUE_W / 4;
   localparam int LZ_W     = $clog2(NIBBLES + 1);
   localparam int DIGIT_W  = $clog2(NIBBLES);
   localparam int STEP_W   = $clog2(NIBBLES + 2);

   // Queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Command codes
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_HEX  = 1'b1;

   // Character codes
   localparam logic [GLYPH_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [GLYPH_W-1:0] CH_TAB     = 8'd9;
   localparam logic [GLYPH_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [GLYPH_W-1:0] CH_X       = 8'h78;
   localparam logic [GLYPH_W-1:0] CH_A_LESS_TEN = 8'h57;
   localparam logic [GLYPH_W-1:0] BLANK_RESET = 8'd32;

   // Steps of a hex item: leading zero, then x, then digits
   localparam logic [STEP_W-1:0] STEP_ZERO  = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_X     = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_DIGIT = STEP_W'(2);

   // One classified item as it waits in the queue
   typedef struct packed {
      logic                is_hex;
      logic [GLYPH_W-1:0]  glyph;
      logic [ATTR_W-1:0]   attr;
      logic [VALUE_W-1:0]  digits;     // first printed nibble at the top
      logic [STEP_W-1:0]   last_step;  // step that carries the final span
   } item_type;

   // Lower-case hex digit glyph
   function automatic logic [GLYPH_W-1:0] hex_glyph(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CH_ZERO + GLYPH_W'(nib);
      end else begin
         return CH_A_LESS_TEN + GLYPH_W'(nib);
      end
   endfunction

endpackage

// ----- hdl/text_console_writer_unit.sv -----
// Text console writer: keeps a column/row cursor over a COLUMNS x ROWS grid
// and turns each request beat into span writes (first cell, glyph, attribute,
// length) plus the cursor position after the span. A character beat gives one
// span; newline and tab give a blank-fill span using the blank glyph register.
// A hex beat gives 3 to 10 spans ("0", "x", then the digits without leading
// zeros, at least one). Character beats are taken one per cycle while the queue
// has room; a hex beat occupies the span sequencer until all its characters
// are printed, and a four-entry queue between the request decoder and the
// sequencer keeps accepting until it fills. Results sit in an output register,
// so a new span is produced in the same cycle the previous one is taken. There
// is no clearing pass after reset.
module text_console_writer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [tcw_pkg::GLYPH_W-1:0]   req_glyph_in,
   input  logic [tcw_pkg::ATTR_W-1:0]    req_attr_in,
   input  logic [tcw_pkg::VALUE_W-1:0]   req_hex_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tcw_pkg::POS_W-1:0]     rsp_cell_index,
   output logic [tcw_pkg::GLYPH_W-1:0]   rsp_glyph_out,
   output logic [tcw_pkg::ATTR_W-1:0]    rsp_attr_out,
   output logic [tcw_pkg::LEN_W-1:0]     rsp_span_length,
   output logic [tcw_pkg::POS_W-1:0]     rsp_cursor_pos,
   output logic                          rsp_last,
   input  logic                          csr_write_en,
   input  logic [tcw_pkg::GLYPH_W-1:0]   csr_write_data
);

   logic [tcw_pkg::GLYPH_W-1:0] blank_glyph_ff, blank_glyph_in;
   tcw_pkg::item_type           front_item;
   tcw_pkg::item_type           head;
   logic                        not_full;
   logic                        head_valid;
   logic                        pop;
   logic                        push;

   // Blank glyph register
   assign blank_glyph_in = csr_write_en ? csr_write_data : blank_glyph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_glyph_ff <= tcw_pkg::BLANK_RESET;
      end else begin
         blank_glyph_ff <= blank_glyph_in;
      end
   end

   assign req_ready = not_full;
   assign push      = req_valid && not_full;

   tcw_front u_front (
      .req_cmd       (req_cmd),
      .req_glyph_in  (req_glyph_in),
      .req_attr_in   (req_attr_in),
      .req_hex_value (req_hex_value),
      .item          (front_item)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .pop        (pop),
      .not_full   (not_full),
      .head_valid (head_valid),
      .head       (head)
   );

   tcw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .blank_glyph     (blank_glyph_ff),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_glyph_out   (rsp_glyph_out),
      .rsp_attr_out    (rsp_attr_out),
      .rsp_span_length (rsp_span_length),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- hdl/tcw_front.sv -----
module tcw_front (
   input  logic                          req_cmd,
   input  logic [tcw_pkg::GLYPH_W-1:0]   req_glyph_in,
   input  logic [tcw_pkg::ATTR_W-1:0]    req_attr_in,
   input  logic [tcw_pkg::VALUE_W-1:0]   req_hex_value,
   output tcw_pkg::item_type             item
);

   logic [tcw_pkg::LZ_W-1:0]  lz;
   logic                      found;
   logic [tcw_pkg::LZ_W-1:0]  ndig;

   // Count leading zero nibbles of the hex value
   always_comb begin
      lz    = tcw_pkg::LZ_W'(tcw_pkg::NIBBLES);
      found = 1'b0;
      for (int i = tcw_pkg::NIBBLES - 1; i >= 0; i--) begin
         if (!found && (req_hex_value[i*4 +: 4] != 4'd0)) begin
            lz    = tcw_pkg::LZ_W'(tcw_pkg::NIBBLES - 1 - i);
            found = 1'b1;
         end
      end
   end

   // Digit count: a zero value still prints one digit
   assign ndig = found ? tcw_pkg::LZ_W'(tcw_pkg::NIBBLES) - lz : tcw_pkg::LZ_W'(1);

   // Classify the beat into a queue entry
   always_comb begin
      item.is_hex = (req_cmd == tcw_pkg::CMD_HEX);
      item.glyph  = req_glyph_in;
      item.attr   = req_attr_in;
      item.digits = req_hex_value << {lz, 2'b00};
      if (req_cmd == tcw_pkg::CMD_HEX) begin
         item.last_step = tcw_pkg::STEP_W'(ndig) + tcw_pkg::STEP_X;
      end else begin
         item.last_step = tcw_pkg::STEP_ZERO;
      end
   end

endmodule

// ----- hdl/tcw_queue.sv -----
`include "assert_macros.svh"

module tcw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tcw_pkg::item_type  push_item,
   input  logic               pop,
   output logic               not_full,
   output logic               head_valid,
   output tcw_pkg::item_type  head
);

   tcw_pkg::item_type                entries [tcw_pkg::QUEUE_DEPTH];
   logic [tcw_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tcw_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tcw_pkg::QPTR_W:0]         count_ff, count_in;

   assign not_full   = (count_ff != (tcw_pkg::QPTR_W+1)'(tcw_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

   `TCW_ASSERT(a_q_bound, count_ff <= (tcw_pkg::QPTR_W+1)'(tcw_pkg::QUEUE_DEPTH), "queue overflow")
   `TCW_ASSERT_NEXT(a_q_fill, push && !pop && count_ff == (tcw_pkg::QPTR_W+1)'(tcw_pkg::QUEUE_DEPTH - 1), !not_full, "queue missed full")

endmodule

// ----- hdl/tcw_back.sv -----
`include "assert_macros.svh"

module tcw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tcw_pkg::GLYPH_W-1:0]   blank_glyph,
   input  logic                          head_valid,
   input  tcw_pkg::item_type             head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tcw_pkg::POS_W-1:0]     rsp_cell_index,
   output logic [tcw_pkg::GLYPH_W-1:0]   rsp_glyph_out,
   output logic [tcw_pkg::ATTR_W-1:0]    rsp_attr_out,
   output logic [tcw_pkg::LEN_W-1:0]     rsp_span_length,
   output logic [tcw_pkg::POS_W-1:0]     rsp_cursor_pos,
   output logic                          rsp_last
);

   localparam logic [tcw_pkg::END_W-1:0] COLS_E = tcw_pkg::END_W'(tcw_pkg::COLUMNS);
   localparam logic [tcw_pkg::END_W-1:0] TAB_E  = tcw_pkg::END_W'(tcw_pkg::TAB_STOP);
   localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

   // Cursor state
   logic [tcw_pkg::COL_W-1:0]    col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [tcw_pkg::POS_W-1:0]    lin_ff, lin_in;
   logic [tcw_pkg::STEP_W-1:0]   step_ff, step_in;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::POS_W-1:0]    cell_ff;
   logic [tcw_pkg::GLYPH_W-1:0]  glyph_ff;
   logic [tcw_pkg::ATTR_W-1:0]   attr_ff;
   logic [tcw_pkg::LEN_W-1:0]    len_ff;
   logic [tcw_pkg::POS_W-1:0]    cursor_ff;
   logic                         last_ff;

   logic                         advance;
   logic                         is_last;
   logic [tcw_pkg::DIGIT_W-1:0]  digit_pos;
   logic [tcw_pkg::VALUE_W-1:0]  digit_word;
   logic [tcw_pkg::GLYPH_W-1:0]  ch;
   logic [tcw_pkg::GLYPH_W-1:0]  glyph;
   logic [tcw_pkg::END_W-1:0]    start;
   logic [tcw_pkg::END_W-1:0]    tab_end;
   logic [tcw_pkg::END_W-1:0]    span_end;
   logic [tcw_pkg::END_W-1:0]    span_len;
   logic                         wrap;

   assign advance = head_valid && (!rsp_valid_ff || rsp_ready);
   assign is_last = (step_ff == head.last_step);
   assign pop     = advance && is_last;

   // Pick the character of this step
   assign digit_pos  = tcw_pkg::DIGIT_W'(step_ff - tcw_pkg::STEP_DIGIT);
   assign digit_word = head.digits << {digit_pos, 2'b00};

   always_comb begin
      if (!head.is_hex) begin
         ch = head.glyph;
      end else if (step_ff == tcw_pkg::STEP_ZERO) begin
         ch = tcw_pkg::CH_ZERO;
      end else if (step_ff == tcw_pkg::STEP_X) begin
         ch = tcw_pkg::CH_X;
      end else begin
         ch = tcw_pkg::hex_glyph(digit_word[tcw_pkg::VALUE_W-1 -: 4]);
      end
   end

   // Span extent: one cell, to the next tab stop, or to the line end
   assign start   = tcw_pkg::END_W'(col_ff);
   assign tab_end = start + TAB_E - (start % TAB_E);

   always_comb begin
      case (ch)
         tcw_pkg::CH_NEWLINE: begin
            span_end = COLS_E;
            glyph    = blank_glyph;
         end
         tcw_pkg::CH_TAB: begin
            span_end = (tab_end > COLS_E) ? COLS_E : tab_end;
            glyph    = blank_glyph;
         end
         default: begin
            span_end = start + 1'b1;
            glyph    = ch;
         end
      endcase
   end

   assign span_len = span_end - start;
   assign wrap     = (span_end >= COLS_E);

   // Next cursor; the linear position adds the span length, or returns to zero when the last row wraps
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      lin_in  = lin_ff;
      step_in = step_ff;
      if (advance) begin
         step_in = is_last ? tcw_pkg::STEP_ZERO : step_ff + 1'b1;
         if (wrap) begin
            col_in = '0;
            if (row_ff == LAST_ROW) begin
               row_in = '0;
               lin_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
               lin_in = lin_ff + tcw_pkg::POS_W'(span_len);
            end
         end else begin
            col_in = tcw_pkg::COL_W'(span_end);
            lin_in = lin_ff + tcw_pkg::POS_W'(span_len);
         end
      end
   end

   // Hold the result until taken, refill on advance
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         lin_ff       <= '0;
         step_ff      <= tcw_pkg::STEP_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         lin_ff       <= lin_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture span payload
   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff   <= lin_ff;
         glyph_ff  <= glyph;
         attr_ff   <= head.attr;
         len_ff    <= tcw_pkg::LEN_W'(span_len);
         cursor_ff <= lin_in;
         last_ff   <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_index  = cell_ff;
   assign rsp_glyph_out   = glyph_ff;
   assign rsp_attr_out    = attr_ff;
   assign rsp_span_length = len_ff;
   assign rsp_cursor_pos  = cursor_ff;
   assign rsp_last        = last_ff;

   `TCW_ASSERT(a_col_range, col_ff < tcw_pkg::COL_W'(tcw_pkg::COLUMNS), "column out of range")
   `TCW_ASSERT(a_row_range, row_ff <= LAST_ROW, "row out of range")
   `TCW_ASSERT(a_lin_track, lin_ff == tcw_pkg::POS_W'(32'(row_ff) * tcw_pkg::COLUMNS + 32'(col_ff)), "linear position out of step")
   `TCW_ASSERT(a_step_bound, !head_valid || step_ff <= head.last_step, "step past final span")

endmodule

// ----- tb/sv/text_console_writer_unit_tb.sv -----
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
   import tcw_pkg::*;

   localparam logic [GLYPH_W-1:0] CH_LOWER_A = 8'h61;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_OFF_SPAN  = 150;

   // One span write as it leaves the block
   typedef struct packed {
      logic [POS_W-1:0]   cell_index;
      logic [GLYPH_W-1:0] glyph;
      logic [ATTR_W-1:0]  attr;
      logic [LEN_W-1:0]   span_len;
      logic [POS_W-1:0]   cursor;
      logic               last;
   } span_type;

   // Cursor tracker plus the queue of span writes still owed by the block
   class span_scoreboard;
      int unsigned        column;
      int unsigned        row;
      logic [GLYPH_W-1:0] blank_glyph;
      span_type           expected_spans[$];
      int unsigned        fail_count;
      int unsigned        items_noted;
      int unsigned        hex_items;
      int unsigned        spans_checked;
      int unsigned        blank_settings;

      function new();
         column         = 0;
         row            = 0;
         blank_glyph    = BLANK_RESET;
         fail_count     = 0;
         items_noted    = 0;
         hex_items      = 0;
         spans_checked  = 0;
         blank_settings = 1;
      endfunction

      function void set_blank(logic [GLYPH_W-1:0] g);
         blank_glyph = g;
         blank_settings++;
      endfunction

      function int unsigned pending();
         return expected_spans.size();
      endfunction

      // Write one span at the cursor, then advance and wrap the cursor
      function void emit_span(logic [GLYPH_W-1:0] ch, logic [ATTR_W-1:0] attr,
                              logic is_last);
         int unsigned start_col;
         int unsigned end_col;
         span_type    s;
         start_col = column;
         if (start_col >= COLUMNS) begin
            start_col = COLUMNS - 1;
            column    = start_col;
         end
         s.cell_index = POS_W'(row * COLUMNS + column);
         if (ch == CH_NEWLINE) begin
            end_col = COLUMNS;
            s.glyph = blank_glyph;
         end else if (ch == CH_TAB) begin
            end_col = start_col + TAB_STOP - (start_col % TAB_STOP);
            if (end_col > COLUMNS) begin
               end_col = COLUMNS;
            end
            s.glyph = blank_glyph;
         end else begin
            end_col = start_col + 1;
            s.glyph = ch;
         end
         column = end_col;
         if (column >= COLUMNS) begin
            column = 0;
            row    = (row < ROWS - 1) ? row + 1 : 0;
         end
         s.attr     = attr;
         s.span_len = LEN_W'(end_col - start_col);
         s.cursor   = POS_W'(row * COLUMNS + column);
         s.last     = is_last;
         expected_spans.push_back(s);
      endfunction

      // Turn one accepted request beat into its span writes
      function void note_request(logic cmd, logic [GLYPH_W-1:0] ch,
                                 logic [ATTR_W-1:0] attr, logic [VALUE_W-1:0] value);
         int                 top;
         logic [3:0]         nib;
         logic [GLYPH_W-1:0] digit;
         items_noted++;
         if (cmd == CMD_CHAR) begin
            emit_span(ch, attr, 1'b1);
         end else begin
            hex_items++;
            // skip leading zero nibbles, keep at least one digit
            top = NIBBLES - 1;
            while (top > 0 && value[top*4 +: 4] == 4'h0) begin
               top--;
            end
            emit_span(CH_ZERO, attr, 1'b0);
            emit_span(CH_X, attr, 1'b0);
            for (int i = top; i >= 0; i--) begin
               nib   = value[i*4 +: 4];
               digit = (nib < 4'd10) ? CH_ZERO + GLYPH_W'(nib)
                                     : CH_LOWER_A + GLYPH_W'(nib - 4'd10);
               emit_span(digit, attr, i == 0);
            end
         end
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns ERROR %s", $time, msg);
         fail_count++;
      endtask

      // Compare one accepted span beat with the oldest expected span
      task check_span(span_type got);
         span_type want;
         spans_checked++;
         if (expected_spans.size() == 0) begin
            report_mismatch($sformatf("unexpected span at cell %0d glyph %0d",
                                      got.cell_index, got.glyph));
         end else begin
            want = expected_spans.pop_front();
            if (got.cell_index !== want.cell_index) begin
               report_mismatch($sformatf("cell_index got %0d expected %0d",
                                         got.cell_index, want.cell_index));
            end
            if (got.glyph !== want.glyph) begin
               report_mismatch($sformatf("glyph_out got %0d expected %0d",
                                         got.glyph, want.glyph));
            end
            if (got.attr !== want.attr) begin
               report_mismatch($sformatf("attr_out got %0d expected %0d",
                                         got.attr, want.attr));
            end
            if (got.span_len !== want.span_len) begin
               report_mismatch($sformatf("span_length got %0d expected %0d",
                                         got.span_len, want.span_len));
            end
            if (got.cursor !== want.cursor) begin
               report_mismatch($sformatf("cursor_pos got %0d expected %0d",
                                         got.cursor, want.cursor));
            end
            if (got.last !== want.last) begin
               report_mismatch($sformatf("last got %0d expected %0d",
                                         got.last, want.last));
            end
         end
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_cmd;
   logic [GLYPH_W-1:0] req_glyph_in;
   logic [ATTR_W-1:0]  req_attr_in;
   logic [VALUE_W-1:0] req_hex_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [POS_W-1:0]   rsp_cell_index;
   logic [GLYPH_W-1:0] rsp_glyph_out;
   logic [ATTR_W-1:0]  rsp_attr_out;
   logic [LEN_W-1:0]   rsp_span_length;
   logic [POS_W-1:0]   rsp_cursor_pos;
   logic               rsp_last;
   logic               csr_write_en;
   logic [GLYPH_W-1:0] csr_write_data;

   span_scoreboard sb = new();
   bit             steady_run;
   bit             hold_off_request;
   int             hold_off_left;
   int             longest_hold;

   text_console_writer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_glyph_in    (req_glyph_in),
      .req_attr_in     (req_attr_in),
      .req_hex_value   (req_hex_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_glyph_out   (rsp_glyph_out),
      .rsp_attr_out    (rsp_attr_out),
      .rsp_span_length (rsp_span_length),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 1'b0;
   end

   always #1 clock = ~clock;

   // Note request beats and check span beats on the values seen at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_cmd, req_glyph_in, req_attr_in, req_hex_value);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_span('{rsp_cell_index, rsp_glyph_out, rsp_attr_out,
                            rsp_span_length, rsp_cursor_pos, rsp_last});
         end
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready     = 1'b0;
      hold_off_left = 0;
      longest_hold  = 0;
      forever begin
         @(posedge clock);
         if (hold_off_left == 0 && hold_off_request) begin
            hold_off_left    = HOLD_OFF_SPAN;
            longest_hold     = HOLD_OFF_SPAN;
            hold_off_request = 1'b0;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_run || ($urandom_range(99) >= 10);
         end
      end
   end

   // Offer one request beat and hold it until accepted
   task automatic send_request(logic cmd, logic [GLYPH_W-1:0] ch,
                               logic [ATTR_W-1:0] attr, logic [VALUE_W-1:0] value);
      if (!steady_run && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_glyph_in  <= ch;
      req_attr_in   <= attr;
      req_hex_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Mix of random characters, newlines, tabs and hex values of any size
   task automatic send_random_item();
      int                 pick;
      logic [GLYPH_W-1:0] ch;
      logic [ATTR_W-1:0]  attr;
      logic [VALUE_W-1:0] value;
      pick  = $urandom_range(99);
      ch    = GLYPH_W'($urandom);
      attr  = ATTR_W'($urandom);
      value = $urandom;
      if (pick < 40) begin
         send_request(CMD_CHAR, ch, attr, value);
      end else if (pick < 55) begin
         send_request(CMD_CHAR, CH_NEWLINE, attr, value);
      end else if (pick < 67) begin
         send_request(CMD_CHAR, CH_TAB, attr, value);
      end else begin
         send_request(CMD_HEX, ch, attr, value >> $urandom_range(32));
      end
   endtask

   // Drop valid and let every owed span drain before touching the register;
   // wait for a clock edge first so the last accepted beat has been noted
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_blank_glyph(logic [GLYPH_W-1:0] g);
      csr_write_en   <= 1'b1;
      csr_write_data <= g;
      sb.set_blank(g);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_CHAR;
      req_glyph_in     = '0;
      req_attr_in      = '0;
      req_hex_value    = '0;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      steady_run       = 1'b0;
      hold_off_request = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, tab stops, hex edge values, last-column tab
      send_request(CMD_CHAR, 8'h41, 8'h07, 32'h0);
      send_request(CMD_CHAR, 8'hff, 8'hff, 32'h0);
      send_request(CMD_CHAR, 8'h00, 8'h00, 32'hffff_ffff);
      send_request(CMD_CHAR, CH_TAB, 8'h1e, 32'h0);
      send_request(CMD_CHAR, CH_TAB, 8'he1, 32'h0);
      send_request(CMD_HEX, CH_NEWLINE, 8'h3c, 32'h0);
      send_request(CMD_HEX, CH_TAB, 8'hc3, 32'hffff_ffff);
      send_request(CMD_HEX, 8'h00, 8'h11, 32'h0000_0001);
      send_request(CMD_HEX, 8'hff, 8'h22, 32'h8000_0000);
      send_request(CMD_HEX, 8'h41, 8'h33, 32'h00ab_cdef);
      send_request(CMD_CHAR, CH_TAB, 8'h44, 32'h0);
      send_request(CMD_CHAR, CH_TAB, 8'h55, 32'h0);
      send_request(CMD_CHAR, CH_TAB, 8'h66, 32'h0);
      send_request(CMD_HEX, 8'h00, 8'h77, 32'h0000_1234);
      send_request(CMD_CHAR, 8'h7e, 8'h88, 32'h0);
      send_request(CMD_CHAR, CH_TAB, 8'h99, 32'h0);
      send_request(CMD_CHAR, CH_NEWLINE, 8'haa, 32'h0);
      send_request(CMD_CHAR, 8'h7a, 8'h55, 32'h0);
      send_request(CMD_CHAR, CH_NEWLINE, 8'hbb, 32'h0);
      send_request(CMD_CHAR, 8'h0b, 8'hcc, 32'h1234_5678);
      send_request(CMD_CHAR, 8'h08, 8'hdd, 32'h0);
      send_request(CMD_HEX, 8'h0a, 8'h80, 32'hdead_beef);

      // Blank glyph at zero; no idling, result side held off while sending
      wait_for_drain();
      write_blank_glyph(8'h00);
      steady_run       = 1'b1;
      hold_off_request = 1'b1;
      repeat (25) send_random_item();
      steady_run = 1'b0;

      // Blank glyph at its top value; run the cursor past the bottom row
      wait_for_drain();
      write_blank_glyph(8'hff);
      repeat (ROWS + 2) send_request(CMD_CHAR, CH_NEWLINE, ATTR_W'($urandom), $urandom);
      repeat (20) send_random_item();

      // Random blank glyph, random traffic with idling on both sides
      wait_for_drain();
      write_blank_glyph(GLYPH_W'($urandom));
      repeat (20) send_random_item();

      wait_for_drain();
      $display("Covered %0d requests (%0d hex) and %0d span writes under %0d blank glyphs,",
               sb.items_noted, sb.hex_items, sb.spans_checked, sb.blank_settings);
      $display("with a %0d-cycle result hold-off and the cursor wrapping past the last row.",
               longest_hold);
      if (sb.fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
